// File: rtl/rsm_pkg.sv
// Package with the constants and the controller state type of the row softmax block.
`timescale 1ns / 1ps
package rsm_pkg;
    localparam int MAX_COLS   = 64;
    localparam int IDX_W      = $clog2(MAX_COLS);
    localparam int LEN_W      = 7;
    localparam int SCORE_W    = 16;
    localparam int PROB_W     = 16;
    localparam int EXP_W      = 17;
    localparam int SUM_W      = 23;
    localparam int POW_BITS   = 13;
    localparam int DIV_STEPS  = 39;
    localparam logic [31:0] EXP_BASE_Q32 = 32'd4278222805;
    localparam logic [15:0] EXP_CUTOFF   = 16'd4096;

    typedef enum logic [7:0] {
        S_LOAD  = 8'b0000_0001,
        S_ERD   = 8'b0000_0010,
        S_EINIT = 8'b0000_0100,
        S_EITER = 8'b0000_1000,
        S_EWR   = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_NRD   = 8'b0100_0000,
        S_NWAIT = 8'b1000_0000
    } state_t;
endpackage

// File: rtl/row_softmax.sv
// Row softmax: loads scores into memory, forms max-subtracted exponentials, then normalizes.
// Load: one score per cycle, stall is low only while a row is being loaded.
// Exponent pass per element: memory read, setup, 13 square-and-multiply steps, write-back;
// steps skipped below a difference of -16. Reciprocal: 39 steps, one quotient bit each.
// Normalize pass per element: exp memory read, multiply into the output register once free.
// Reset clears the controller, counters and row length (64); the memories are not cleared.
`timescale 1ns / 1ps
module row_softmax (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rsm_pkg::LEN_W-1:0]     row_length,
    input  logic                          score_valid,
    output logic                          score_stall,
    input  logic signed [rsm_pkg::SCORE_W-1:0] score,
    output logic                          prob_valid,
    input  logic                          prob_stall,
    output logic [rsm_pkg::PROB_W-1:0]    prob,
    output logic                          last
);
    import rsm_pkg::*;

    logic [SCORE_W-1:0] score_mem [MAX_COLS];
    logic [EXP_W-1:0]   exp_mem   [MAX_COLS];
    logic [SCORE_W-1:0] score_rd_reg;
    logic [EXP_W-1:0]   exp_rd_reg;

    state_t state_reg, state_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   load_cnt_reg, load_cnt_next;
    logic [LEN_W-1:0]   row_n_reg, row_n_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [SCORE_W-1:0] max_reg, max_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [32:0]        acc_reg, acc_next;
    logic [31:0]        base_reg, base_next;
    logic [POW_BITS-1:0] m_reg, m_next;
    logic [3:0]         k_reg, k_next;
    logic [23:0]        rem_reg, rem_next;
    logic [DIV_STEPS-1:0] dvd_reg, dvd_next;
    logic [31:0]        quo_reg, quo_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [PROB_W-1:0]  prob_reg, prob_next;
    logic               last_reg, last_next;

    logic               score_take;
    logic [LEN_W-1:0]   eff_n;
    logic [LEN_W-1:0]   cnt_inc;
    logic signed [SCORE_W:0] diff;
    logic [64:0]        acc_prod, acc_rnd;
    logic [63:0]        base_prod, base_rnd;
    logic [32:0]        e_rnd;
    logic [23:0]        trial;
    logic [48:0]        norm_prod, norm_rnd;
    logic [26:0]        norm_q;
    logic               out_free;
    logic               idx_last;

    assign cfg_ready   = 1'b1;
    assign score_stall = (state_reg != S_LOAD);
    assign score_take  = score_valid && !score_stall;
    assign prob_valid  = out_valid_reg;
    assign prob        = prob_reg;
    assign last        = last_reg;
    assign out_free    = !out_valid_reg || !prob_stall;

    always_comb
    begin
        if (len_reg == '0)
            eff_n = LEN_W'(1);
        else if (len_reg > LEN_W'(MAX_COLS))
            eff_n = LEN_W'(MAX_COLS);
        else
            eff_n = len_reg;
    end

    assign cnt_inc  = load_cnt_reg + LEN_W'(1);
    assign idx_last = ({1'b0, idx_reg} == row_n_reg - LEN_W'(1));
    assign diff     = {max_reg[SCORE_W-1], max_reg} -
                      {score_rd_reg[SCORE_W-1], score_rd_reg};

    assign acc_prod  = acc_reg * {33'd0, base_reg};
    assign acc_rnd   = acc_prod + (65'd1 << 31);
    assign base_prod = {32'd0, base_reg} * {32'd0, base_reg};
    assign base_rnd  = base_prod + (64'd1 << 31);
    assign e_rnd     = acc_reg + 33'd32768;

    assign trial     = {rem_reg[22:0], dvd_reg[DIV_STEPS-1]};

    assign norm_prod = {32'd0, exp_rd_reg} * {17'd0, quo_reg};
    assign norm_rnd  = norm_prod + (49'd1 << 21);
    assign norm_q    = norm_rnd[48:22];

    always_ff @(posedge clk)
    begin
        if (score_take)
            score_mem[load_cnt_reg[IDX_W-1:0]] <= score;
        if (state_reg == S_EWR)
            exp_mem[idx_reg] <= e_rnd[32:16];
        score_rd_reg <= score_mem[idx_reg];
        exp_rd_reg   <= exp_mem[idx_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        row_n_next     = row_n_reg;
        idx_next       = idx_reg;
        max_next       = max_reg;
        sum_next       = sum_reg;
        acc_next       = acc_reg;
        base_next      = base_reg;
        m_next         = m_reg;
        k_next         = k_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && prob_stall;
        prob_next      = prob_reg;
        last_next      = last_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (score_take)
                begin
                    if (load_cnt_reg == '0 || score > max_reg)
                        max_next = score;
                    if (cnt_inc >= eff_n)
                    begin
                        row_n_next    = cnt_inc;
                        load_cnt_next = '0;
                        idx_next      = '0;
                        sum_next      = '0;
                        state_next    = S_ERD;
                    end
                    else
                        load_cnt_next = cnt_inc;
                end
            end
            S_ERD:
                state_next = S_EINIT;
            S_EINIT:
            begin
                acc_next  = 33'h1_0000_0000;
                base_next = EXP_BASE_Q32;
                k_next    = '0;
                m_next    = diff[POW_BITS-1:0];
                // Differences below -16 give a zero exponential.
                if (diff[SCORE_W-1:0] > EXP_CUTOFF)
                begin
                    acc_next   = '0;
                    state_next = S_EWR;
                end
                else
                    state_next = S_EITER;
            end
            S_EITER:
            begin
                if (m_reg[k_reg])
                    acc_next = acc_rnd[64:32];
                base_next = base_rnd[63:32];
                k_next    = k_reg + 4'd1;
                if (k_reg == 4'(POW_BITS - 1))
                    state_next = S_EWR;
            end
            S_EWR:
            begin
                sum_next = sum_reg + SUM_W'(e_rnd[32:16]);
                if (idx_last)
                begin
                    idx_next   = '0;
                    rem_next   = '0;
                    quo_next   = '0;
                    dcnt_next  = '0;
                    dvd_next   = {1'b1, 16'd0, sum_next[SUM_W-1:1]};
                    state_next = S_DIV;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_ERD;
                end
            end
            S_DIV:
            begin
                dvd_next = {dvd_reg[DIV_STEPS-2:0], 1'b0};
                if (trial >= {1'b0, sum_reg})
                begin
                    rem_next = trial - {1'b0, sum_reg};
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = trial;
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == 6'(DIV_STEPS - 1))
                begin
                    if (sum_reg == '0)
                        quo_next = '0;
                    state_next = S_NRD;
                end
            end
            S_NRD:
                state_next = S_NWAIT;
            S_NWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    prob_next      = (norm_q > 27'd65535) ? 16'hFFFF : norm_q[15:0];
                    last_next      = idx_last;
                    if (idx_last)
                    begin
                        idx_next   = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_NRD;
                    end
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            len_reg       <= LEN_W'(MAX_COLS);
            load_cnt_reg  <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            dcnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_valid && cfg_ready)
                len_reg <= row_length;
            load_cnt_reg  <= load_cnt_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_n_reg <= row_n_next;
        max_reg   <= max_next;
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        m_reg     <= m_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        quo_reg   <= quo_next;
        prob_reg  <= prob_next;
        last_reg  <= last_next;
    end
endmodule

// File: bench/tb_top.sv
// Self-checking bench for the row softmax block: scoreboard class, drivers and monitor.
`timescale 1ns / 1ps
module tb_top;
    import rsm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 370;
    localparam int DRAIN_CYCLES   = 50;

    class softmax_scoreboard;
        logic [LEN_W-1:0]          length_reg;
        logic signed [SCORE_W-1:0] row_scores [MAX_COLS];
        int unsigned               fill;
        logic signed [SCORE_W-1:0] peak;
        logic [PROB_W-1:0]         prob_q [$];
        bit                        last_q [$];
        int                        errors;

        function void reset_state();
            length_reg = 7'd64;
            fill = 0;
            peak = '0;
            errors = 0;
            prob_q.delete();
            last_q.delete();
        endfunction

        // exp(-m/256) in Q1.16 by square-and-multiply over Q0.32 products.
        function automatic longint unsigned exp_neg(int unsigned m);
            longint unsigned base;
            longint unsigned acc;
            base = EXP_BASE_Q32;
            acc = 64'd1 << 32;
            if (m > EXP_CUTOFF)
                return 0;
            for (int k = 0; k < POW_BITS; k++)
            begin
                if ((m >> k) & 1)
                    acc = (acc * base + (64'd1 << 31)) >> 32;
                base = (base * base + (64'd1 << 31)) >> 32;
            end
            return (acc + (64'd1 << 15)) >> 16;
        endfunction

        function void note_score(logic signed [SCORE_W-1:0] s);
            int unsigned     need;
            int unsigned     n;
            longint unsigned e [MAX_COLS];
            longint unsigned sum;
            longint unsigned recip;
            longint unsigned p;
            row_scores[fill] = s;
            if (fill == 0 || s > peak)
                peak = s;
            fill++;
            need = length_reg;
            if (need < 1)
                need = 1;
            if (need > MAX_COLS)
                need = MAX_COLS;
            if (fill < need)
                return;
            n = fill;
            sum = 0;
            for (int i = 0; i < n; i++)
            begin
                e[i] = exp_neg(int'(peak) - int'(row_scores[i]));
                sum = (sum + e[i]) & 64'h7F_FFFF;
            end
            recip = (sum == 0) ? 0 : ((64'd1 << 38) + (sum >> 1)) / sum;
            for (int i = 0; i < n; i++)
            begin
                p = (e[i] * recip + (64'd1 << 21)) >> 22;
                if (p > 65535)
                    p = 65535;
                prob_q.push_back(p[15:0]);
                last_q.push_back(i + 1 == n);
            end
            fill = 0;
        endfunction

        function void check_prob(logic [PROB_W-1:0] p, logic l);
            logic [PROB_W-1:0] want_p;
            bit                want_l;
            if (prob_q.size() == 0)
            begin
                $display("%0t: unexpected result prob=%0d last=%0b", $time, p, l);
                errors++;
                return;
            end
            want_p = prob_q.pop_front();
            want_l = last_q.pop_front();
            if (p !== want_p)
            begin
                $display("%0t: prob mismatch, expected %0d, actual %0d", $time, want_p, p);
                errors++;
            end
            if (l !== want_l)
            begin
                $display("%0t: last mismatch, expected %0b, actual %0b", $time, want_l, l);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [LEN_W-1:0]          row_length;
    logic                      score_valid;
    logic                      score_stall;
    logic signed [SCORE_W-1:0] score;
    logic                      prob_valid;
    logic                      prob_stall;
    logic [PROB_W-1:0]         prob;
    logic                      last;

    softmax_scoreboard sb;
    int  idle_cycles;
    bit  no_gaps;
    int  scores_sent;

    row_softmax dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .row_length  (row_length),
        .score_valid (score_valid),
        .score_stall (score_stall),
        .score       (score),
        .prob_valid  (prob_valid),
        .prob_stall  (prob_stall),
        .prob        (prob),
        .last        (last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int gap_length();
        if (no_gaps)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(5, 20);
        return $urandom_range(0, 2);
    endfunction

    task automatic send_score(logic signed [SCORE_W-1:0] s);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            score_valid <= 1'b0;
            score <= SCORE_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        score_valid <= 1'b1;
        score <= s;
        do @(posedge clk); while (score_stall);
        sb.note_score(s);
        scores_sent++;
    endtask

    task automatic wait_drained();
        score_valid <= 1'b0;
        while (sb.prob_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_length(logic [LEN_W-1:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        row_length <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.length_reg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_row(int n, bit tight);
        int unsigned top;
        top = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if (tight)
                send_score(SCORE_W'(top[15:0] - $urandom_range(0, 4600)));
            else
                send_score(SCORE_W'($urandom));
        end
    endtask

    // Result side: random stall with short and occasional long holds.
    always @(posedge clk or negedge rst_n)
    begin : result_side
        int hold;
        if (!rst_n)
        begin
            prob_stall <= 1'b0;
            hold = 0;
        end
        else
        begin
            if (prob_valid && !prob_stall)
                sb.check_prob(prob, last);
            if (hold > 0)
            begin
                hold--;
                prob_stall <= 1'b1;
            end
            else if (!no_gaps && $urandom_range(0, 3) == 0)
            begin
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : 0;
                prob_stall <= 1'b1;
            end
            else
                prob_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((score_valid && !score_stall) || (prob_valid && !prob_stall) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        sb.reset_state();
        no_gaps = 1'b0;
        scores_sent = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        row_length = '0;
        score_valid = 1'b0;
        score = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: single-element rows, length 0 acting as 1, cutoff edges.
        write_length(7'd1);
        send_score(16'sh7FFF);
        send_score(-16'sh8000);
        write_length(7'd0);
        send_score(16'sd0);
        send_score(-16'sd1);
        write_length(7'd3);
        send_score(16'sh7FFF);
        send_score(-16'sh8000);
        send_score(16'sd0);
        send_score(16'sd0);
        send_score(16'sd0);
        send_score(16'sd0);
        // Differences of exactly -16 and just below it.
        send_score(16'sd100);
        send_score(16'sd100 - 16'sd4096);
        send_score(16'sd100 - 16'sd4097);
        send_score(16'sd5);
        send_score(16'sd4);
        send_score(16'sd6);

        // Random part over several lengths, extremes included.
        write_length(7'd64);
        send_row(64, 1'b1);
        write_length(7'd127);
        no_gaps = 1'b1;
        send_row(64, 1'b1);
        no_gaps = 1'b0;
        while (scores_sent < RANDOM_ITEMS - 64)
        begin
            write_length(LEN_W'($urandom_range(0, 20)));
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 4))
                send_row((sb.length_reg == 0) ? 1 : sb.length_reg, $urandom_range(0, 3) != 0);
        end
        write_length(7'd64);
        send_row(64, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.prob_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: sim.f
rtl/rsm_pkg.sv
rtl/row_softmax.sv
bench/tb_top.sv
